// File: rtl/sc1kd_pkg.sv
// Shared types, scan code constants and the character key test for the
// set-1 scan code key decoder. No dependencies.
`default_nettype none

package sc1kd_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned IdxW  = 7;

  localparam logic [CodeW-1:0] ScPrefix     = 8'hE0;
  localparam logic [CodeW-1:0] ScCtrlMake   = 8'h1D;
  localparam logic [CodeW-1:0] ScCtrlBreak  = 8'h9D;
  localparam logic [CodeW-1:0] ScLShMake    = 8'h2A;
  localparam logic [CodeW-1:0] ScLShBreak   = 8'hAA;
  localparam logic [CodeW-1:0] ScRShMake    = 8'h36;
  localparam logic [CodeW-1:0] ScRShBreak   = 8'hB6;
  localparam logic [CodeW-1:0] ScAltMake    = 8'h38;
  localparam logic [CodeW-1:0] ScAltBreak   = 8'hB8;
  localparam logic [CodeW-1:0] ScCapsLock   = 8'h3A;
  localparam logic [CodeW-1:0] ScNumLock    = 8'h45;
  localparam logic [CodeW-1:0] ScScrollLock = 8'h46;

  // Modifier flag bit positions
  localparam int unsigned ModLCtrl  = 0;
  localparam int unsigned ModRCtrl  = 1;
  localparam int unsigned ModLShift = 2;
  localparam int unsigned ModRShift = 3;
  localparam int unsigned ModLAlt   = 4;
  localparam int unsigned ModRAlt   = 5;

  // Lock flag bit positions
  localparam int unsigned LockCaps   = 0;
  localparam int unsigned LockNum    = 1;
  localparam int unsigned LockScroll = 2;

  typedef struct packed {
    logic       prefix;
    logic [5:0] mods;
    logic [2:0] locks;
    logic       key_down;
  } kbd_state_t;

  // Nonzero entries of the US key map; indices past the table are zero.
  function automatic logic is_char_key(input logic [IdxW-1:0] idx);
    logic hit;
    case (idx) inside
      [7'd1:7'd28], [7'd30:7'd41], [7'd43:7'd53], 7'd55, 7'd57,
      [7'd71:7'd83]: hit = 1'b1;
      default:       hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sc1kd_update.sv
// Next-state logic for one scan code byte: prefix, modifiers, locks and
// the key-down flag. Depends on sc1kd_pkg.
`default_nettype none

module sc1kd_update import sc1kd_pkg::*; (
  input  kbd_state_t       state_i,
  input  logic [CodeW-1:0] code_i,
  output kbd_state_t       state_o,
  output logic             emit_o
);

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    if (code_i == ScPrefix) begin
      // arm prefix, no report
      state_o.prefix = 1'b1;
    end else begin
      if (state_i.prefix) begin
        case (code_i)
          ScCtrlMake:  state_o.mods[ModRCtrl] = 1'b1;
          ScCtrlBreak: state_o.mods[ModRCtrl] = 1'b0;
          ScAltMake:   state_o.mods[ModRAlt]  = 1'b1;
          ScAltBreak:  state_o.mods[ModRAlt]  = 1'b0;
          default:     ;
        endcase
        state_o.prefix = 1'b0;
      end else begin
        case (code_i)
          ScCtrlMake:   state_o.mods[ModLCtrl]  = 1'b1;
          ScCtrlBreak:  state_o.mods[ModLCtrl]  = 1'b0;
          ScLShMake:    state_o.mods[ModLShift] = 1'b1;
          ScLShBreak:   state_o.mods[ModLShift] = 1'b0;
          ScRShMake:    state_o.mods[ModRShift] = 1'b1;
          ScRShBreak:   state_o.mods[ModRShift] = 1'b0;
          ScAltMake:    state_o.mods[ModLAlt]   = 1'b1;
          ScAltBreak:   state_o.mods[ModLAlt]   = 1'b0;
          ScCapsLock:   state_o.locks[LockCaps]   = ~state_i.locks[LockCaps];
          ScNumLock:    state_o.locks[LockNum]    = ~state_i.locks[LockNum];
          ScScrollLock: state_o.locks[LockScroll] = ~state_i.locks[LockScroll];
          default:      ;
        endcase
        // bare 0x80 has index zero, which is never a character key
        if (is_char_key(code_i[IdxW-1:0])) begin
          state_o.key_down = ~code_i[CodeW-1];
        end
      end
      emit_o = state_o.key_down;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scan_code_set1_key_decoder.sv
// Set-1 scan code key decoder: tracks modifiers, locks and a key-down flag.
// Path: input register, then result register. Throughput: one byte per cycle
// while the result side does not stall, set by the single-pass update between
// the two registers. Reset clears all key state and the valid flags of both
// register stages. Depends on sc1kd_pkg and sc1kd_update.
`default_nettype none

module scan_code_set1_key_decoder import sc1kd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CodeW-1:0] scan_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] code_out_o,
  output logic             left_ctrl_o,
  output logic             right_ctrl_o,
  output logic             left_shift_o,
  output logic             right_shift_o,
  output logic             left_alt_o,
  output logic             right_alt_o,
  output logic             caps_lock_o,
  output logic             num_lock_o,
  output logic             scroll_lock_o
);

  logic             in_valid_q;
  logic [CodeW-1:0] code_q;
  kbd_state_t       state_q, state_d;
  logic             emit;
  logic             advance;
  logic             load_out;
  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;
  logic [5:0]       out_mods_q;
  logic [2:0]       out_locks_q;

  sc1kd_update u_update (
    .state_i (state_q),
    .code_i  (code_q),
    .state_o (state_d),
    .emit_o  (emit)
  );

  // advance the input stage when its result has room or there is none
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i || !emit);
  assign load_out   = advance && emit;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      code_q <= scan_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_code_q  <= code_q;
      out_mods_q  <= state_d.mods;
      out_locks_q <= state_d.locks;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_out_o    = out_code_q;
  assign left_ctrl_o   = out_mods_q[ModLCtrl];
  assign right_ctrl_o  = out_mods_q[ModRCtrl];
  assign left_shift_o  = out_mods_q[ModLShift];
  assign right_shift_o = out_mods_q[ModRShift];
  assign left_alt_o    = out_mods_q[ModLAlt];
  assign right_alt_o   = out_mods_q[ModRAlt];
  assign caps_lock_o   = out_locks_q[LockCaps];
  assign num_lock_o    = out_locks_q[LockNum];
  assign scroll_lock_o = out_locks_q[LockScroll];

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input stage");

  a_report_key_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> state_q.key_down)
    else $error("result loaded while key-down flag clear");

  a_prefix_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && code_q == ScPrefix) |=> (state_q.prefix && !$rose(out_valid_q)))
    else $error("prefix byte produced a result or left prefix clear");

endmodule

`default_nettype wire

// File: dv/scan_code_set1_key_decoder_tb.sv
// Self-checking testbench for scan_code_set1_key_decoder: directed and random scan code
// streams with random idling on both channels, checked against an internal key state predictor.
// Depends on sc1kd_pkg and the decoder RTL.
module scan_code_set1_key_decoder_tb;
  import sc1kd_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomCodes = 1550;

  // Scan codes without a name in the package
  localparam logic [CodeW-1:0] ScKeyAMake   = 8'h1E;
  localparam logic [CodeW-1:0] ScKeyABreak  = 8'h9E;
  localparam logic [CodeW-1:0] ScBareBreak  = 8'h80;
  localparam logic [CodeW-1:0] ScZero       = 8'h00;
  localparam logic [CodeW-1:0] ScTopMake    = 8'h7F;
  localparam logic [CodeW-1:0] ScTopBreak   = 8'hFF;
  localparam logic [CodeW-1:0] ScOffMapBrk  = 8'hDA;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [5:0]       mods;
    logic [2:0]       locks;
  } key_report_t;

  class KeyReportBoard;
    key_report_t  pending_q[$];
    bit           prefix_armed;
    bit [5:0]     mods;
    bit [2:0]     locks;
    bit           key_held;
    int unsigned  errors;
    int unsigned  codes_noted;
    int unsigned  reports_checked;
    string        mod_names[6]  = '{"left_ctrl", "right_ctrl", "left_shift",
                                    "right_shift", "left_alt", "right_alt"};
    string        lock_names[3] = '{"caps_lock", "num_lock", "scroll_lock"};

    // Printable keys of the US map; index 0 and everything past the table miss.
    function bit is_map_key(input logic [IdxW-1:0] idx);
      return (idx >= 1 && idx <= 28) || (idx >= 30 && idx <= 41) ||
             (idx >= 43 && idx <= 53) || idx == 55 || idx == 57 ||
             (idx >= 71 && idx <= 83);
    endfunction

    function void note_code(input logic [CodeW-1:0] code);
      codes_noted++;
      if (code == ScPrefix) begin
        prefix_armed = 1'b1;
        return;
      end
      if (prefix_armed) begin
        case (code)
          ScCtrlMake:  mods[ModRCtrl] = 1'b1;
          ScCtrlBreak: mods[ModRCtrl] = 1'b0;
          ScAltMake:   mods[ModRAlt]  = 1'b1;
          ScAltBreak:  mods[ModRAlt]  = 1'b0;
          default: ;
        endcase
        prefix_armed = 1'b0;
      end else begin
        case (code)
          ScCtrlMake:   mods[ModLCtrl]  = 1'b1;
          ScCtrlBreak:  mods[ModLCtrl]  = 1'b0;
          ScLShMake:    mods[ModLShift] = 1'b1;
          ScLShBreak:   mods[ModLShift] = 1'b0;
          ScRShMake:    mods[ModRShift] = 1'b1;
          ScRShBreak:   mods[ModRShift] = 1'b0;
          ScAltMake:    mods[ModLAlt]   = 1'b1;
          ScAltBreak:   mods[ModLAlt]   = 1'b0;
          ScCapsLock:   locks[LockCaps]   = ~locks[LockCaps];
          ScNumLock:    locks[LockNum]    = ~locks[LockNum];
          ScScrollLock: locks[LockScroll] = ~locks[LockScroll];
          default: ;
        endcase
        // Index 0 is never a map key, so a bare 0x80 leaves the flag alone.
        if (is_map_key(code[IdxW-1:0])) key_held = ~code[CodeW-1];
      end
      if (key_held) pending_q.push_back('{code: code, mods: mods, locks: locks});
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_report(input key_report_t got);
      key_report_t want;
      reports_checked++;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected report, got code %02h mods %06b locks %03b",
                       got.code, got.mods, got.locks));
        return;
      end
      want = pending_q.pop_front();
      if (got.code !== want.code)
        flag($sformatf("code_out exp %02h got %02h", want.code, got.code));
      for (int i = 0; i < 6; i++)
        if (got.mods[i] !== want.mods[i])
          flag($sformatf("%s exp %0b got %0b (code %02h)", mod_names[i],
                         want.mods[i], got.mods[i], want.code));
      for (int i = 0; i < 3; i++)
        if (got.locks[i] !== want.locks[i])
          flag($sformatf("%s exp %0b got %0b (code %02h)", lock_names[i],
                         want.locks[i], got.locks[i], want.code));
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [CodeW-1:0] scan_code_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [CodeW-1:0] code_out_o;
  logic             left_ctrl_o, right_ctrl_o, left_shift_o, right_shift_o;
  logic             left_alt_o, right_alt_o, caps_lock_o, num_lock_o, scroll_lock_o;
  logic             hold_active   = 1'b0;

  KeyReportBoard    sb;

  scan_code_set1_key_decoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .scan_code_i,
    .out_valid_o,
    .out_stall_i,
    .code_out_o,
    .left_ctrl_o,
    .right_ctrl_o,
    .left_shift_o,
    .right_shift_o,
    .left_alt_o,
    .right_alt_o,
    .caps_lock_o,
    .num_lock_o,
    .scroll_lock_o
  );

  always #1 clk_i = ~clk_i;

  // Neither side idles while this window of accepted codes is running.
  function automatic bit steady_window();
    return sb.codes_noted >= 700 && sb.codes_noted < 1000;
  endfunction

  // Offer one code; return at the edge that accepts it.
  task automatic send_code(input logic [CodeW-1:0] code);
    while (!steady_window() && $urandom_range(99) < 24) begin
      in_valid_i  <= 1'b0;
      scan_code_i <= CodeW'($urandom);
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_code(code);
  endtask

  task automatic pick_map_key(output logic [IdxW-1:0] idx);
    do idx = IdxW'($urandom_range(1, 83)); while (!sb.is_map_key(idx));
  endtask

  // One well-formed key event or a stray byte.
  task automatic send_random_event();
    logic [IdxW-1:0] idx;
    int unsigned     roll;
    roll = $urandom_range(99);
    if (roll < 25) begin
      pick_map_key(idx);
      send_code({1'b0, idx});
    end else if (roll < 40) begin
      pick_map_key(idx);
      send_code({1'b1, idx});
    end else if (roll < 55) begin
      case ($urandom_range(7))
        0: send_code(ScCtrlMake);
        1: send_code(ScCtrlBreak);
        2: send_code(ScLShMake);
        3: send_code(ScLShBreak);
        4: send_code(ScRShMake);
        5: send_code(ScRShBreak);
        6: send_code(ScAltMake);
        default: send_code(ScAltBreak);
      endcase
    end else if (roll < 65) begin
      case ($urandom_range(2))
        0: send_code(ScCapsLock);
        1: send_code(ScNumLock);
        default: send_code(ScScrollLock);
      endcase
    end else if (roll < 80) begin
      send_code(ScPrefix);
      case ($urandom_range(4))
        0: send_code(ScCtrlMake);
        1: send_code(ScCtrlBreak);
        2: send_code(ScAltMake);
        3: send_code(ScAltBreak);
        default: send_code(CodeW'($urandom));
      endcase
    end else begin
      send_code(CodeW'($urandom));
    end
  endtask

  // Result side: check each transaction, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_report({code_out_o, right_alt_o, left_alt_o, right_shift_o,
                         left_shift_o, right_ctrl_o, left_ctrl_o,
                         scroll_lock_o, num_lock_o, caps_lock_o});
      out_stall_i <= hold_active || (!steady_window() && $urandom_range(99) < 24);
    end
  end

  // Hold the result side off long enough to back up the input.
  initial begin
    wait (rst_ni);
    while (sb.reports_checked < 60) @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[scan_code_set1_key_decoder] ERROR");
    $finish;
  end

  initial begin
    logic [CodeW-1:0] directed_q[$];
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, every modifier and lock, prefix repeats, bare break, off-map break.
    directed_q = '{ScZero, ScKeyAMake, ScBareBreak, ScTopBreak, ScTopMake,
                   ScCtrlMake, ScLShMake, ScRShMake, ScAltMake,
                   ScCapsLock, ScNumLock, ScScrollLock,
                   ScPrefix, ScPrefix, ScCtrlMake, ScPrefix, ScAltMake,
                   ScCtrlBreak, ScLShBreak, ScRShBreak, ScAltBreak,
                   ScPrefix, ScAltBreak, ScPrefix, ScCtrlBreak,
                   ScOffMapBrk, ScKeyABreak};
    foreach (directed_q[i]) send_code(directed_q[i]);

    while (sb.codes_noted < directed_q.size() + RandomCodes) send_random_event();
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0 || hold_active) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[scan_code_set1_key_decoder] OK");
    end else begin
      $display("[scan_code_set1_key_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sc1kd_pkg.sv
rtl/sc1kd_update.sv
rtl/scan_code_set1_key_decoder.sv
dv/scan_code_set1_key_decoder_tb.sv
